>>> design/mffd_pkg.sv
// ----------------------------------------------------------------------------
// mffd_pkg: shared types and constants of the motor feedback frame decoder
// Payload structs, result codes, register indexes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package mffd_pkg;

  // Frame layout
  localparam int FRAME_LEN   = 10;
  localparam int CRC_LEN     = FRAME_LEN - 1;
  localparam int STORE_DEPTH = 8;              // bytes 0..7 are kept for decode
  localparam logic [7:0] CRC_POLY = 8'h8C;     // reflected CRC-8/Maxim
  localparam logic [3:0] FRAME_LEN_CNT = 4'(FRAME_LEN);
  localparam logic [3:0] LAST_BYTE_CNT = 4'(FRAME_LEN - 1);

  // Position wrap limits, 32768 counts per turn
  localparam logic signed [17:0] HALF_TURN = 18'sd16384;
  localparam logic signed [17:0] FULL_TURN = 18'sd32768;

  // Result queue depth between front and back
  localparam int QDEPTH = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WHEEL0_ID    = 2'd0;
  localparam logic [1:0] CFG_WHEEL1_ID    = 2'd1;
  localparam logic [1:0] CFG_WHEEL0_SCALE = 2'd2;
  localparam logic [1:0] CFG_WHEEL1_SCALE = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_CRC   = 2'd2,
    ST_ID    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       wheel_slot;
    logic       timeout;
  } in_t;

  typedef struct packed {
    logic               result_wheel;
    status_t            status;
    logic [3:0]         bytes_received;
    logic signed [23:0] velocity_rpm;
    logic signed [15:0] current_raw;
    logic signed [47:0] position_counts;
  } out_t;

  // One ended frame as classified by the front
  typedef struct packed {
    logic       wheel;
    status_t    status;
    logic [3:0] bytes_received;
    logic [15:0] current;
    logic [15:0] velocity;
    logic [15:0] raw_pos;
  } evt_t;

  // Advance the CRC by one byte, LSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> design/motor_feedback_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder_core: motor feedback frame decoder top level
// Decodes 10-byte CRC-8/Maxim protected feedback frames for up to two wheels.
// ----------------------------------------------------------------------------
// The block takes one received byte (or a timeout marker) per cycle while
// in_ready is high and gives one result per ended frame: on the tenth byte,
// or on a timeout item, which reports a short frame. The result of a frame
// passes the result queue, the stage B registers and the output register
// before out_valid rises; the output register and the two-entry result queue
// between the byte front end and the position back end keep bytes flowing
// while a result waits. in_ready falls only while that queue is full, so a
// downstream that takes results at least as fast as frames end never stalls
// the input. Wheel ids and scales are written through cfg_we/cfg_index/cfg_data
// and take effect on the next frame end; write them only while no frame result
// is pending. Position accumulates per wheel in counts and wraps at 48 bits.
module motor_feedback_frame_decoder_core #(
  parameter int WHEEL_COUNT = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mffd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mffd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data
);

  logic [WHEEL_COUNT-1:0][7:0] wheel_id;
  logic [WHEEL_COUNT-1:0][7:0] wheel_scale;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  mffd_pkg::evt_t q_in;
  mffd_pkg::evt_t q_out;

  // Configuration registers, one id and one scale per wheel
  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_cfg
    localparam logic [1:0] ID_IDX    = (w == 0) ? mffd_pkg::CFG_WHEEL0_ID
                                                : mffd_pkg::CFG_WHEEL1_ID;
    localparam logic [1:0] SCALE_IDX = (w == 0) ? mffd_pkg::CFG_WHEEL0_SCALE
                                                : mffd_pkg::CFG_WHEEL1_SCALE;
    always_ff @(posedge clk) begin
      if (rst) begin
        wheel_id[w]    <= 8'd0;
        wheel_scale[w] <= 8'd1;
      end else if (cfg_we) begin
        if (cfg_index == ID_IDX) begin
          wheel_id[w] <= cfg_data;
        end
        if (cfg_index == SCALE_IDX) begin
          wheel_scale[w] <= cfg_data;
        end
      end
    end
  end

  mffd_front #(
    .WHEEL_COUNT (WHEEL_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wheel_id (wheel_id),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  mffd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  mffd_back #(
    .WHEEL_COUNT (WHEEL_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wheel_scale (wheel_scale),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> design/mffd_front.sv
// ----------------------------------------------------------------------------
// mffd_front: byte collection and frame classification
// Counts bytes, runs the CRC, keeps bytes 0..7 and emits one event per frame.
// ----------------------------------------------------------------------------
module mffd_front #(
  parameter int WHEEL_COUNT = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mffd_pkg::in_t               in_data,
  input  logic [WHEEL_COUNT-1:0][7:0] wheel_id,
  input  logic                        q_full,
  output logic                        q_push,
  output mffd_pkg::evt_t              q_data
);

  logic [3:0] byte_count;
  logic [7:0] running_crc;
  logic [7:0] frame_store [mffd_pkg::STORE_DEPTH];

  logic accept;
  logic end_frame;
  logic slot;
  logic [7:0] exp_id;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Saturate the slot to the last wheel
  assign slot   = (32'(in_data.wheel_slot) >= WHEEL_COUNT) ? 1'(WHEEL_COUNT - 1)
                                                            : in_data.wheel_slot;
  assign exp_id = wheel_id[slot];

  assign end_frame = accept && !in_data.timeout && (byte_count == mffd_pkg::LAST_BYTE_CNT);
  assign q_push    = end_frame || (accept && in_data.timeout);

  // Classify the ending frame
  always_comb begin
    q_data.wheel    = slot;
    q_data.current  = {frame_store[2], frame_store[3]};
    q_data.velocity = {frame_store[4], frame_store[5]};
    q_data.raw_pos  = {frame_store[6], frame_store[7]};
    if (in_data.timeout) begin
      q_data.status         = mffd_pkg::ST_SHORT;
      q_data.bytes_received = byte_count;
    end else begin
      q_data.bytes_received = mffd_pkg::FRAME_LEN_CNT;
      if (in_data.rx_byte != running_crc) begin
        q_data.status = mffd_pkg::ST_CRC;
      end else if (frame_store[0] != exp_id) begin
        q_data.status = mffd_pkg::ST_ID;
      end else begin
        q_data.status = mffd_pkg::ST_OK;
      end
    end
  end

  // Advance count and CRC, restart on frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= '0;
    end else if (accept) begin
      if (q_push) begin
        byte_count  <= '0;
        running_crc <= '0;
      end else begin
        byte_count  <= byte_count + 4'd1;
        running_crc <= mffd_pkg::crc_byte(running_crc, in_data.rx_byte);
      end
    end
  end

  // Hold the bytes needed for decode
  always_ff @(posedge clk) begin
    if (accept && !in_data.timeout && (byte_count < 4'(mffd_pkg::STORE_DEPTH))) begin
      frame_store[byte_count[2:0]] <= in_data.rx_byte;
    end
  end

endmodule

>>> design/mffd_queue.sv
// ----------------------------------------------------------------------------
// mffd_queue: small event queue between front and back
// Two-entry FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mffd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mffd_pkg::evt_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mffd_pkg::evt_t pop_data
);

  localparam int PW = $clog2(mffd_pkg::QDEPTH);
  localparam int CW = $clog2(mffd_pkg::QDEPTH + 1);

  mffd_pkg::evt_t entry [mffd_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(mffd_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entry[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store event
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/mffd_back.sv
// ----------------------------------------------------------------------------
// mffd_back: position tracking and result formatting
// Stage A unwraps the position delta and scales it; stage B accumulates and
// loads the output register.
// ----------------------------------------------------------------------------
module mffd_back #(
  parameter int WHEEL_COUNT = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [WHEEL_COUNT-1:0][7:0] wheel_scale,
  input  logic                        q_valid,
  input  mffd_pkg::evt_t              q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mffd_pkg::out_t              out_data
);

  // Per-wheel tracking state
  logic [15:0]        last_raw [WHEEL_COUNT];
  logic               pos_seen [WHEEL_COUNT];
  logic signed [47:0] pos_total [WHEEL_COUNT];

  // Stage A combinational
  logic signed [7:0]  scale_a;
  logic [15:0]        last_eff;
  logic signed [17:0] d_raw;
  logic signed [17:0] d_wrap;
  logic               ok_a;

  // Stage B registers
  logic                b_valid;
  logic                b_wheel;
  mffd_pkg::status_t   b_status;
  logic [3:0]          b_bytes;
  logic signed [15:0]  b_current;
  logic signed [23:0]  b_vel;
  logic signed [25:0]  b_prod;

  logic               b_adv;
  logic signed [47:0] total_next;

  assign b_adv = b_valid && (!out_valid || out_ready);
  assign q_pop = q_valid && (!b_valid || b_adv);
  assign ok_a  = (q_data.status == mffd_pkg::ST_OK);

  // Unwrap the position delta into half a turn
  always_comb begin
    scale_a  = $signed(wheel_scale[q_data.wheel]);
    last_eff = pos_seen[q_data.wheel] ? last_raw[q_data.wheel] : q_data.raw_pos;
    d_raw    = $signed({2'b00, q_data.raw_pos}) - $signed({2'b00, last_eff});
    if (d_raw > mffd_pkg::HALF_TURN) begin
      d_wrap = d_raw - mffd_pkg::FULL_TURN;
    end else if (d_raw < -mffd_pkg::HALF_TURN) begin
      d_wrap = d_raw + mffd_pkg::FULL_TURN;
    end else begin
      d_wrap = d_raw;
    end
  end

  // Latch last position on good frames
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        last_raw[w] <= '0;
        pos_seen[w] <= 1'b0;
      end
    end else if (q_pop && ok_a) begin
      last_raw[q_data.wheel] <= q_data.raw_pos;
      pos_seen[q_data.wheel] <= 1'b1;
    end
  end

  // Stage B valid
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (q_pop) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  // Stage B payload: scale velocity and delta
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_wheel   <= q_data.wheel;
      b_status  <= q_data.status;
      b_bytes   <= q_data.bytes_received;
      b_current <= $signed(q_data.current);
      b_vel     <= scale_a * $signed(q_data.velocity);
      b_prod    <= scale_a * d_wrap;
    end
  end

  assign total_next = pos_total[b_wheel] - {{22{b_prod[25]}}, b_prod};

  // Accumulate position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        pos_total[w] <= '0;
      end
    end else if (b_adv && (b_status == mffd_pkg::ST_OK)) begin
      pos_total[b_wheel] <= total_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data.result_wheel   <= b_wheel;
      out_data.status         <= b_status;
      out_data.bytes_received <= b_bytes;
      if (b_status == mffd_pkg::ST_OK) begin
        out_data.velocity_rpm    <= b_vel;
        out_data.current_raw     <= b_current;
        out_data.position_counts <= total_next;
      end else begin
        out_data.velocity_rpm    <= '0;
        out_data.current_raw     <= '0;
        out_data.position_counts <= '0;
      end
    end
  end

endmodule

>>> design/mffd_checker.sv
// ----------------------------------------------------------------------------
// mffd_checker: port-level checks of the frame decoder
// Watches the result channel for reset, stall and payload consistency.
// ----------------------------------------------------------------------------
module mffd_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input mffd_pkg::out_t out_data
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Drop payload on failed frames
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != mffd_pkg::ST_OK) |->
      (out_data.velocity_rpm == '0) && (out_data.current_raw == '0) &&
      (out_data.position_counts == '0))
    else $error("failed frame carries payload");

  // Full frames report all bytes, short frames fewer
  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((out_data.status == mffd_pkg::ST_SHORT) && (out_data.bytes_received < 4'd10)) ||
      ((out_data.status != mffd_pkg::ST_SHORT) && (out_data.bytes_received == 4'd10)))
    else $error("byte count does not match status");

endmodule

bind motor_feedback_frame_decoder_core mffd_checker u_mffd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/motor_feedback_frame_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder_core_tb: self-checking bench for the decoder
// Feeds byte and timeout transfers under random bursts and output stalls, with
// one long output hold-off. A tracker rebuilds each frame, its CRC and the
// per-wheel position totals, and compares every reported frame field by field.
// ----------------------------------------------------------------------------
typedef logic [7:0] frame_bytes_t [mffd_pkg::FRAME_LEN];

typedef enum {
  FK_GOOD,
  FK_BAD_CRC,
  FK_BAD_ID,
  FK_SHORT,
  FK_NOISE
} frame_kind_t;

class wheel_feedback_tracker;
  localparam logic [7:0] MAXIM_POLY = 8'h8C;
  localparam int HALF_TURN_COUNTS = 16384;
  localparam int FULL_TURN_COUNTS = 32768;

  logic [7:0]        frame_buf [mffd_pkg::FRAME_LEN];
  int unsigned       byte_cnt;
  logic [7:0]        crc_acc;
  logic [15:0]       last_raw [2];
  bit                raw_seen [2];
  logic [47:0]       position_acc [2];
  logic [7:0]        wheel_id [2];
  logic signed [7:0] wheel_scale [2];
  mffd_pkg::out_t    expected_reports [$];
  int unsigned       mismatch_count;

  function new();
    byte_cnt = 0;
    crc_acc = '0;
    mismatch_count = 0;
    for (int i = 0; i < 2; i++) begin
      last_raw[i] = '0;
      raw_seen[i] = 1'b0;
      position_acc[i] = '0;
      wheel_id[i] = '0;
      wheel_scale[i] = 8'sd1;
    end
  endfunction

  // Shift one byte into a reflected CRC-8, low bit first
  static function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] data);
    logic mix;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ data[k];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ MAXIM_POLY;
      end
    end
    return crc;
  endfunction

  static function logic [7:0] frame_crc(frame_bytes_t bytes);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < mffd_pkg::FRAME_LEN - 1; i++) begin
      crc = crc_update(crc, bytes[i]);
    end
    return crc;
  endfunction

  function void set_register(logic [1:0] index, logic [7:0] value);
    case (index)
      mffd_pkg::CFG_WHEEL0_ID:    wheel_id[0] = value;
      mffd_pkg::CFG_WHEEL1_ID:    wheel_id[1] = value;
      mffd_pkg::CFG_WHEEL0_SCALE: wheel_scale[0] = signed'(value);
      mffd_pkg::CFG_WHEEL1_SCALE: wheel_scale[1] = signed'(value);
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  // Advance the frame by one accepted transfer; queue a report if it ends
  function void note_byte(mffd_pkg::in_t item);
    mffd_pkg::out_t     rep;
    bit                 slot;
    int                 delta;
    longint             step;
    logic signed [15:0] cur;
    logic signed [15:0] vel;
    logic [15:0]        raw;
    rep = '0;
    slot = item.wheel_slot;
    rep.result_wheel = slot;
    if (item.timeout) begin
      rep.status = mffd_pkg::ST_SHORT;
      rep.bytes_received = 4'(byte_cnt);
    end else begin
      frame_buf[byte_cnt] = item.rx_byte;
      if (byte_cnt < mffd_pkg::FRAME_LEN - 1) begin
        crc_acc = crc_update(crc_acc, item.rx_byte);
      end
      byte_cnt++;
      if (byte_cnt < mffd_pkg::FRAME_LEN) begin
        return;
      end
      rep.bytes_received = 4'(mffd_pkg::FRAME_LEN);
      if (frame_buf[mffd_pkg::FRAME_LEN - 1] != crc_acc) begin
        rep.status = mffd_pkg::ST_CRC;
      end else if (frame_buf[0] != wheel_id[slot]) begin
        rep.status = mffd_pkg::ST_ID;
      end else begin
        cur = {frame_buf[2], frame_buf[3]};
        vel = {frame_buf[4], frame_buf[5]};
        raw = {frame_buf[6], frame_buf[7]};
        // First good frame of a wheel only latches its position
        if (!raw_seen[slot]) begin
          last_raw[slot] = raw;
          raw_seen[slot] = 1'b1;
        end
        delta = int'(raw) - int'(last_raw[slot]);
        last_raw[slot] = raw;
        // Fold the delta into half a turn either way
        if (delta > HALF_TURN_COUNTS) begin
          delta -= FULL_TURN_COUNTS;
        end else if (delta < -HALF_TURN_COUNTS) begin
          delta += FULL_TURN_COUNTS;
        end
        step = longint'(wheel_scale[slot]) * longint'(delta);
        position_acc[slot] = position_acc[slot] - step[47:0];
        rep.status = mffd_pkg::ST_OK;
        rep.velocity_rpm = 24'(longint'(wheel_scale[slot]) * longint'(vel));
        rep.current_raw = cur;
        rep.position_counts = position_acc[slot];
      end
    end
    byte_cnt = 0;
    crc_acc = '0;
    expected_reports.insert(expected_reports.size(), rep);
  endfunction

  task report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task compare_field(string label, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", label, got, want));
    end
  endtask

  task check_report(mffd_pkg::out_t got);
    mffd_pkg::out_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("frame report with no ended frame pending");
      return;
    end
    want = expected_reports.pop_front();
    compare_field("result_wheel", got.result_wheel, want.result_wheel);
    compare_field("status", got.status, want.status);
    compare_field("bytes_received", got.bytes_received, want.bytes_received);
    compare_field("velocity_rpm", got.velocity_rpm, want.velocity_rpm);
    compare_field("current_raw", got.current_raw, want.current_raw);
    compare_field("position_counts", got.position_counts, want.position_counts);
  endtask
endclass

module motor_feedback_frame_decoder_core_tb;

  localparam int CLK_PERIOD = 2;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 95;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  mffd_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  mffd_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = mffd_pkg::CFG_WHEEL0_ID;
  logic [7:0]     cfg_data = '0;

  wheel_feedback_tracker tracker;

  int unsigned items_sent = 0;
  int unsigned burst_left = 4;
  bit          gaps_off = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;
  bit          run_ready = 1'b1;
  int unsigned cycle_count = 0;

  motor_feedback_frame_decoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: check each report transfer, stall in random runs, honor long holds
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        tracker.check_report(out_data);
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 2) != 0);
          run_left = run_ready ? $urandom_range(1, 30) : $urandom_range(1, 10);
        end
        run_left--;
        out_ready <= run_ready;
      end
    end
  end

  // Offer one item and hold it until transferred; idle between bursts
  task automatic offer(mffd_pkg::in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_byte(item);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0 && !gaps_off) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // Send the first count bytes; optionally close the frame with a timeout
  task automatic send_bytes(frame_bytes_t bytes, int count, bit slot, bit ends_short);
    mffd_pkg::in_t item;
    for (int i = 0; i < count; i++) begin
      item.rx_byte = bytes[i % mffd_pkg::FRAME_LEN];
      item.wheel_slot = (i == mffd_pkg::FRAME_LEN - 1) ? slot : 1'($urandom);
      item.timeout = 1'b0;
      offer(item);
    end
    if (ends_short) begin
      item.rx_byte = 8'($urandom);
      item.wheel_slot = slot;
      item.timeout = 1'b1;
      offer(item);
    end
  endtask

  // Build a frame of the given kind; the position lands near wrap points often
  function automatic void build_frame(frame_kind_t kind, bit slot, output frame_bytes_t bytes);
    logic [15:0] last;
    logic [15:0] raw;
    last = tracker.last_raw[slot];
    case ($urandom_range(0, 5))
      0, 1:    raw = 16'($urandom);
      2:       raw = last + 16'($urandom_range(0, 64)) - 16'd32;
      3:       raw = last + 16'(16384 + $urandom_range(0, 1));
      default: raw = last - 16'(16384 + $urandom_range(0, 1));
    endcase
    foreach (bytes[i]) begin
      bytes[i] = 8'($urandom);
    end
    bytes[0] = tracker.wheel_id[slot];
    if (kind == FK_BAD_ID) begin
      bytes[0] = bytes[0] ^ 8'($urandom_range(1, 255));
    end
    bytes[6] = raw[15:8];
    bytes[7] = raw[7:0];
    bytes[mffd_pkg::FRAME_LEN - 1] = tracker.frame_crc(bytes);
    if (kind == FK_BAD_CRC) begin
      bytes[mffd_pkg::FRAME_LEN - 1] = bytes[mffd_pkg::FRAME_LEN - 1] ^
                                       8'($urandom_range(1, 255));
    end
  endfunction

  // Drop valid, drain every pending report, then let the pipeline settle
  task automatic wait_idle();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic [7:0] id0, logic [7:0] id1,
                                logic [7:0] scale0, logic [7:0] scale1);
    logic [7:0] values [4];
    logic [1:0] regs [4];
    values = '{id0, id1, scale0, scale1};
    regs = '{mffd_pkg::CFG_WHEEL0_ID, mffd_pkg::CFG_WHEEL1_ID,
             mffd_pkg::CFG_WHEEL0_SCALE, mffd_pkg::CFG_WHEEL1_SCALE};
    foreach (regs[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= values[i];
      @(posedge clk);
      tracker.set_register(regs[i], values[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, plus errors and noise
  task automatic run_phase(int unsigned goal, bit pressure);
    frame_bytes_t bytes;
    frame_kind_t  kind;
    int unsigned  start;
    int unsigned  pick;
    bit           slot;
    start = items_sent;
    if (pressure) begin
      gaps_off = 1'b1;
      hold_requests++;
    end
    while (items_sent - start < goal) begin
      pick = $urandom_range(0, 99);
      slot = 1'($urandom);
      kind = (pick < 60) ? FK_GOOD :
             (pick < 70) ? FK_BAD_CRC :
             (pick < 80) ? FK_BAD_ID :
             (pick < 92) ? FK_SHORT : FK_NOISE;
      // Realign with a lone timeout if noise left a partial frame
      if (kind != FK_NOISE && tracker.byte_cnt != 0) begin
        send_bytes(bytes, 0, slot, 1'b1);
      end
      build_frame(kind, slot, bytes);
      case (kind)
        FK_SHORT: send_bytes(bytes, $urandom_range(0, mffd_pkg::FRAME_LEN - 1), slot, 1'b1);
        FK_NOISE: send_bytes(bytes, $urandom_range(1, 12), slot, 1'b0);
        default:  send_bytes(bytes, mffd_pkg::FRAME_LEN, slot, 1'b0);
      endcase
    end
    gaps_off = 1'b0;
    wait_idle();
  endtask

  initial begin
    frame_bytes_t bytes;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: lone timeout, extreme good frame (first latch),
    // bad CRC, bad id, then a frame cut short after two bytes
    send_bytes(bytes, 0, 1'b1, 1'b1);
    build_frame(FK_GOOD, 1'b0, bytes);
    bytes[1] = 8'h00;
    bytes[2] = 8'h80;
    bytes[3] = 8'h00;
    bytes[4] = 8'h7F;
    bytes[5] = 8'hFF;
    bytes[6] = 8'hFF;
    bytes[7] = 8'hFF;
    bytes[8] = 8'h55;
    bytes[mffd_pkg::FRAME_LEN - 1] = tracker.frame_crc(bytes);
    send_bytes(bytes, mffd_pkg::FRAME_LEN, 1'b0, 1'b0);
    build_frame(FK_BAD_CRC, 1'b1, bytes);
    send_bytes(bytes, mffd_pkg::FRAME_LEN, 1'b1, 1'b0);
    build_frame(FK_BAD_ID, 1'b1, bytes);
    send_bytes(bytes, mffd_pkg::FRAME_LEN, 1'b1, 1'b0);
    build_frame(FK_GOOD, 1'b0, bytes);
    send_bytes(bytes, 2, 1'b0, 1'b1);
    wait_idle();

    // Random phases over several settings, extremes included
    write_settings(8'h00, 8'hFF, 8'h80, 8'h7F);
    run_phase(PHASE_ITEMS, 1'b0);
    write_settings(8'($urandom), 8'($urandom), 8'h00, 8'h01);
    run_phase(PHASE_ITEMS, 1'b0);
    write_settings(8'hFF, 8'h00, 8'h7F, 8'h80);
    run_phase(PHASE_ITEMS, 1'b1);
    write_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(PHASE_ITEMS, 1'b0);
    write_settings(8'($urandom), 8'($urandom), 8'hFF, 8'($urandom));
    run_phase(PHASE_ITEMS, 1'b0);

    if (tracker.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mffd_pkg.sv
design/mffd_front.sv
design/mffd_queue.sv
design/mffd_back.sv
design/motor_feedback_frame_decoder_core.sv
design/mffd_checker.sv
sim/motor_feedback_frame_decoder_core_tb.sv
